>>> sv/sm3_pkg.sv
// sm3_pkg: shared types and constants for the sm3 hash engine
// no dependencies
package sm3_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } t_state;

    localparam logic [31:0] TJ_LOW  = 32'h79CC4519;
    localparam logic [31:0] TJ_HIGH = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [255:0] SM3_IV = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

>>> sv/sm3_hash_engine.sv
// sm3_hash_engine: sm3 hash of a word-wise byte message, one round per cycle
// depends on sm3_pkg
//
// channel | dir | handshake            | payload
// input   | in  | i_valid / o_ready    | i_data  (t_in_beat)
// output  | out | o_valid / i_ready    | o_data  (t_out_beat)
//
// a full block is loaded, run through 64 rounds and then folded; the
// message schedule is a 16-word sliding window that advances with each round.
// a non-last beat is taken; if it fills a block, no more are taken until that block is compressed.
// a last beat pads one word per cycle, compresses one or two blocks and
// then emits eight digest beats; the output register holds under stall.
// reset (synchronous, active low) loads the initial vector.
module sm3_hash_engine
    import sm3_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);

    t_state r_state, n_state;
    logic [31:0] r_win [16];
    logic [31:0] r_cv  [8];
    logic [31:0] r_wk  [8];
    logic [4:0]  r_fill;
    logic [60:0] r_bytes;
    logic [5:0]  r_round;
    logic        r_final;
    logic [3:0]  r_pad_cnt;
    logic [2:0]  r_emit;

    // padding word and push control
    logic        accept;
    logic [2:0]  eff_n;
    logic [60:0] bytes_sum;
    logic [63:0] bits;
    logic [31:0] pad_word;
    logic        push;
    logic [31:0] push_word;
    logic [31:0] first_pad;
    logic [31:0] keep;

    assign accept = i_valid && o_ready;
    assign eff_n  = (!i_data.last_word || i_data.byte_count > 3'd4) ? 3'd4 : i_data.byte_count;
    assign bytes_sum = r_bytes + 61'(eff_n);
    assign bits   = {r_bytes, 3'b000};
    assign keep   = ~(32'hFFFFFFFF >> {eff_n, 3'b000});
    assign first_pad = (eff_n == 3'd4) ? i_data.message_word
                     : (i_data.message_word & keep)
                       | ({24'd0, PAD_BYTE} << (5'd24 - {eff_n[1:0], 3'b000}));

    // pad sequence: r_pad_cnt 0 means emit 0x80 word (after full last word),
    // 2 means the length high word went out and the low word follows
    always_comb begin
        if (r_pad_cnt == 4'd0)      pad_word = {PAD_BYTE, 24'd0};
        else if (r_pad_cnt == 4'd2) pad_word = bits[31:0];
        else if (r_fill == 5'd14)   pad_word = bits[63:32];
        else                        pad_word = 32'd0;
    end

    always_comb begin
        push = 1'b0;
        push_word = pad_word;
        if (r_state == ST_IDLE && accept) begin
            push = 1'b1;
            push_word = first_pad;
        end else if (r_state == ST_PAD) begin
            push = 1'b1;
        end
    end

    // message schedule and round datapath
    logic [31:0] w16, wj, wpj, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
    assign wj  = r_win[0];
    assign w16 = perm1(r_win[0] ^ r_win[7] ^ rotl(r_win[13], 5'd15))
               ^ rotl(r_win[3], 5'd7) ^ r_win[10];
    assign wpj = r_win[0] ^ r_win[4];
    assign tj  = r_round[5:4] == 2'd0 ? TJ_LOW : TJ_HIGH;
    assign a12 = rotl(r_wk[0], 5'd12);
    assign ss1 = rotl(a12 + r_wk[4] + rotl(tj, r_round[4:0]), 5'd7);
    assign ss2 = ss1 ^ a12;
    always_comb begin
        if (r_round[5:4] == 2'd0) begin
            ff = r_wk[0] ^ r_wk[1] ^ r_wk[2];
            gg = r_wk[4] ^ r_wk[5] ^ r_wk[6];
        end else begin
            ff = (r_wk[0] & r_wk[1]) | (r_wk[0] & r_wk[2]) | (r_wk[1] & r_wk[2]);
            gg = (r_wk[4] & r_wk[5]) | (~r_wk[4] & r_wk[6]);
        end
    end
    assign tt1 = ff + r_wk[3] + ss2 + wpj;
    assign tt2 = gg + r_wk[7] + ss1 + wj;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) begin
                if (r_fill == 5'd15) n_state = ST_EXPAND;
                else if (i_data.last_word) n_state = ST_PAD;
            end
            ST_PAD:    if (r_fill == 5'd15) n_state = ST_EXPAND;
            ST_EXPAND: n_state = ST_ROUND;
            ST_ROUND:  if (r_round == 6'd63) n_state = ST_FOLD;
            ST_FOLD:   n_state = !r_final ? ST_IDLE
                                 : (r_pad_cnt == 4'd15 ? ST_EMIT : ST_PAD);
            ST_EMIT:   if (i_ready && r_emit == 3'd7) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = (r_state == ST_IDLE);
        o_valid = (r_state == ST_EMIT);
        o_data.digest_word = r_cv[r_emit];
        o_data.word_index  = r_emit;
        o_data.digest_last = (r_emit == 3'd7);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_bytes <= '0;
            r_round <= '0;
            r_final <= 1'b0;
            r_pad_cnt <= '0;
            r_emit  <= '0;
            for (int k = 0; k < 8; k++) r_cv[k] <= SM3_IV[255-32*k -: 32];
        end else begin
            r_state <= n_state;
            if (push) r_fill <= (r_fill == 5'd15) ? 5'd0 : r_fill + 5'd1;
            if (r_state == ST_IDLE && accept) begin
                r_bytes <= bytes_sum;
                r_final <= i_data.last_word;
                // pad count 0 requests a 0x80 word next; else zeros
                r_pad_cnt <= (i_data.last_word && eff_n == 3'd4) ? 4'd0 : 4'd1;
            end
            // length words only after the 0x80 word, in the same block
            if (r_state == ST_PAD) begin
                if (r_fill == 5'd15)
                    r_pad_cnt <= (r_pad_cnt == 4'd2) ? 4'd15 : 4'd1;
                else if (r_fill == 5'd14 && r_pad_cnt != 4'd0)
                    r_pad_cnt <= 4'd2;
                else
                    r_pad_cnt <= 4'd1;
            end
            if (r_state == ST_ROUND) r_round <= r_round + 6'd1;
            if (r_state == ST_FOLD)
                for (int k = 0; k < 8; k++) r_cv[k] <= r_cv[k] ^ r_wk[k];
            if (r_state == ST_EMIT && i_ready) begin
                r_emit <= r_emit + 3'd1;
                if (r_emit == 3'd7) begin
                    for (int k = 0; k < 8; k++) r_cv[k] <= SM3_IV[255-32*k -: 32];
                    r_bytes <= '0;
                    r_final <= 1'b0;
                end
            end
        end
    end

    // schedule window and working registers
    always_ff @(posedge i_clk) begin
        if (push) begin
            for (int k = 0; k < 15; k++) r_win[k] <= r_win[k+1];
            r_win[15] <= push_word;
        end else if (r_state == ST_ROUND) begin
            for (int k = 0; k < 15; k++) r_win[k] <= r_win[k+1];
            r_win[15] <= w16;
        end
        if (r_state == ST_EXPAND) begin
            for (int k = 0; k < 8; k++) r_wk[k] <= r_cv[k];
        end else if (r_state == ST_ROUND) begin
            r_wk[3] <= r_wk[2];
            r_wk[2] <= rotl(r_wk[1], 5'd9);
            r_wk[1] <= r_wk[0];
            r_wk[0] <= tt1;
            r_wk[7] <= r_wk[6];
            r_wk[6] <= rotl(r_wk[5], 5'd19);
            r_wk[5] <= r_wk[4];
            r_wk[4] <= perm0(tt2);
        end
    end

    // assertions
    a_round_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_round == 6'd63) |=> r_state == ST_FOLD)
        else $error("round count did not end in fold");
    a_round_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EXPAND |-> r_round == 6'd0 && r_fill == 5'd0)
        else $error("compression started with stale counters");
    a_emit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken during digest output");
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_data))
        else $error("digest beat changed under stall");

endmodule
